// ----- hw/rtl/stf_pkg.sv -----
// ----------------------------------------------------------------------------
// stf_pkg: shared definitions for the slot table allocator
// sizes, operation and status codes, beat layouts and ring control
// ----------------------------------------------------------------------------
package stf_pkg;

  localparam int CAPACITY     = 256;
  localparam int DEFAULT_GROW = 16;

  // derived sizes
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CFG_W  = 9;
  localparam int WIDE_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

  // fixed field widths
  localparam int VAL_W  = 32;
  localparam int OPC_W  = 3;
  localparam int SIDX_W = 8;
  localparam int STS_W  = 3;
  localparam int USED_W = 9;
  localparam int REG_W  = 1;

  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 56;

  localparam logic [IDX_W-1:0] LAST_K = IDX_W'(CAPACITY - 1);

  typedef enum logic [OPC_W-1:0] {
    OP_ADD     = 3'd0,
    OP_WRITE   = 3'd1,
    OP_RMV_VAL = 3'd2,
    OP_RMV_IDX = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 3'd0,
    STS_ZERO     = 3'd1,
    STS_BADIDX   = 3'd2,
    STS_NOTFOUND = 3'd3,
    STS_NOMATCH  = 3'd4,
    STS_NOMEM    = 3'd5
  } status_t;

  typedef enum logic [REG_W-1:0] {
    REG_INITIAL_SLOTS = 1'd0,
    REG_GROW_STEP     = 1'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // packed msb first: the first field sits in the highest bits
  typedef struct packed {
    logic [VAL_W-1:0]  handle_value;
    logic [SIDX_W-1:0] slot_index;
    logic [OPC_W-1:0]  opcode;
  } item_t;

  typedef struct packed {
    logic [USED_W-1:0] used_slots;
    logic [VAL_W-1:0]  read_value;
    logic [SIDX_W-1:0] slot_out;
    status_t           status;
  } result_t;

  typedef struct packed {
    logic             shift;
    logic [VAL_W-1:0] feed;
  } ring_t;

endpackage

// ----- hw/rtl/slot_table_first_free_allocator.sv -----
// ----------------------------------------------------------------------------
// slot_table_first_free_allocator: handle table with first-free add
// a ring of CAPACITY slot cells rotated past one head tap per operation
// ----------------------------------------------------------------------------
// sequence: a rejected operation goes from idle straight to the finish state;
//   a scanning operation rotates the ring one full revolution past the head
// one operation at a time: a new beat is taken only after the previous result
//   has passed into the output register
// reset: synchronous, clears every slot cell, the count and the growth at
//   once; registers return to initial_slots 16 and grow_step 0
// ----------------------------------------------------------------------------
module slot_table_first_free_allocator (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [stf_pkg::REG_W-1:0]    cfg_addr,
  input  logic [stf_pkg::CFG_W-1:0]    cfg_wdata,
  // input stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [stf_pkg::S_DATA_W-1:0] s_tdata,  // opcode, slot_index, handle_value
  // result stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [stf_pkg::M_DATA_W-1:0] m_tdata   // status, slot_out, read_value, used_slots
);
  import stf_pkg::*;

  localparam int ITEM_W = $bits(item_t);
  localparam int RES_W  = $bits(result_t);

  item_t   in_item;
  ring_t   ring;
  result_t result;
  result_t out_q;
  logic    res_valid;
  logic    res_ready;

  // cell values, cell 0 is the head tap
  logic [VAL_W-1:0] cell_q [CAPACITY];

  assign in_item = item_t'(s_tdata[ITEM_W-1:0]);

  // ring of slot cells, the last cell takes the edited head value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] d;
    if (i == CAPACITY - 1) begin : g_tail
      assign d = ring.feed;
    end else begin : g_link
      assign d = cell_q[i+1];
    end
    stf_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ring.shift),
      .d     (d),
      .q     (cell_q[i])
    );
  end

  stf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .head      (cell_q[0]),
    .ring      (ring),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .result    (result)
  );

  // output register frees the sequencer unless a result beat waits unaccepted
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= result;
    end
  end

  assign m_tdata = {(M_DATA_W - RES_W)'(0), out_q};

endmodule

// ----- hw/rtl/stf_cell.sv -----
// ----------------------------------------------------------------------------
// stf_cell: one slot of the rotating table
// holds a slot value and takes its neighbor's value on every shift
// ----------------------------------------------------------------------------
module stf_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      shift,
  input  logic [stf_pkg::VAL_W-1:0] d,
  output logic [stf_pkg::VAL_W-1:0] q
);
  import stf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

// ----- hw/rtl/stf_ctrl.sv -----
// ----------------------------------------------------------------------------
// stf_ctrl: sequencer for the slot table
// decodes an operation, rejects it early or rotates the ring once past the
// head tap and edits the slot at the head, keeps the count, growth and config
// ----------------------------------------------------------------------------
module stf_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [stf_pkg::REG_W-1:0] cfg_addr,
  input  logic [stf_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  stf_pkg::item_t            in_item,
  input  logic [stf_pkg::VAL_W-1:0] head,
  output stf_pkg::ring_t            ring,
  output logic                      res_valid,
  input  logic                      res_ready,
  output stf_pkg::result_t          result
);
  import stf_pkg::*;

  state_t state, state_next;

  logic [CFG_W-1:0] initial_slots;
  logic [CFG_W-1:0] grow_step;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] grown, grown_next;

  // per-operation registers
  op_t              op;
  logic [SIDX_W-1:0] idx;
  logic [VAL_W-1:0] val;
  logic [CNT_W-1:0] size, lim, base;
  logic             grow;
  status_t          status, status_next;
  logic [IDX_W-1:0] slot, slot_next;
  logic [VAL_W-1:0] rd, rd_next;
  logic             done, done_next;
  logic [IDX_W-1:0] k;

  // decode at accept
  logic [WIDE_W-1:0] base_w, sum_w, size_w, step_w, grow_w, idx_w, cnt_w, lim_w;
  logic              dec_early, dec_grow;
  status_t           dec_status;

  always_comb begin
    base_w = (WIDE_W'(initial_slots) > WIDE_W'(CAPACITY)) ? WIDE_W'(CAPACITY)
                                                          : WIDE_W'(initial_slots);
    sum_w  = base_w + WIDE_W'(grown);
    size_w = (sum_w > WIDE_W'(CAPACITY)) ? WIDE_W'(CAPACITY) : sum_w;
    step_w = (grow_step != '0) ? WIDE_W'(grow_step) : WIDE_W'(DEFAULT_GROW);
    grow_w = size_w + step_w;
    idx_w  = WIDE_W'(in_item.slot_index);
    cnt_w  = WIDE_W'(count);
    lim_w      = size_w;
    dec_grow   = 1'b0;
    dec_early  = 1'b1;
    dec_status = STS_BADIDX;
    case (in_item.opcode)
      OP_ADD: begin
        if (in_item.handle_value == '0) begin
          dec_status = STS_ZERO;
        end else if (cnt_w >= size_w && grow_w > WIDE_W'(CAPACITY)) begin
          dec_status = STS_NOMEM;
        end else begin
          dec_early  = 1'b0;
          dec_status = STS_NOMEM;
          if (cnt_w >= size_w) begin
            lim_w    = grow_w;
            dec_grow = 1'b1;
          end
        end
      end
      OP_WRITE, OP_READ: begin
        if (idx_w < size_w) begin
          dec_early  = 1'b0;
          dec_status = STS_OK;
        end
      end
      OP_RMV_VAL: begin
        if (in_item.handle_value == '0) begin
          dec_status = STS_ZERO;
        end else if (cnt_w <= size_w) begin
          dec_early  = 1'b0;
          dec_status = STS_NOTFOUND;
        end
      end
      OP_RMV_IDX: begin
        if (in_item.handle_value != '0 && idx_w < size_w) begin
          dec_early  = 1'b0;
          dec_status = STS_NOMATCH;
        end
      end
      default: begin
      end
    endcase
  end

  // head edit during the scan
  logic [WIDE_W-1:0] kx, ix;

  always_comb begin
    kx          = WIDE_W'(k);
    ix          = WIDE_W'(idx);
    ring.feed   = head;
    count_next  = count;
    grown_next  = grown;
    status_next = status;
    slot_next   = slot;
    rd_next     = rd;
    done_next   = done;
    if (state == S_SCAN) begin
      case (op)
        OP_ADD: begin
          if (!done && kx < WIDE_W'(lim) && head == '0) begin
            ring.feed   = val;
            done_next   = 1'b1;
            slot_next   = k;
            status_next = STS_OK;
            count_next  = count + CNT_W'(1);
            if (grow) begin
              grown_next = lim - base;
            end
          end
        end
        OP_WRITE: begin
          if (kx == ix) begin
            ring.feed = val;
            if (head == '0 && val != '0) begin
              count_next = count + CNT_W'(1);
            end else if (head != '0 && val == '0) begin
              count_next = count - CNT_W'(1);
            end
          end
        end
        OP_RMV_VAL: begin
          if (!done && kx < WIDE_W'(size) && head == val) begin
            ring.feed   = '0;
            done_next   = 1'b1;
            status_next = STS_OK;
            count_next  = count - CNT_W'(1);
          end
        end
        OP_RMV_IDX: begin
          if (kx == ix && head == val) begin
            ring.feed   = '0;
            status_next = STS_OK;
            count_next  = count - CNT_W'(1);
          end
        end
        OP_READ: begin
          if (kx == ix) begin
            rd_next = head;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = dec_early ? S_FINISH : S_SCAN;
      S_SCAN:   if (k == LAST_K) state_next = S_FINISH;
      S_FINISH: if (res_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = (state == S_IDLE);
    res_valid  = (state == S_FINISH);
    ring.shift = (state == S_SCAN);
  end

  assign result.status     = status;
  assign result.slot_out   = SIDX_W'(slot);
  assign result.read_value = rd;
  assign result.used_slots = USED_W'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      initial_slots <= CFG_W'(16);
      grow_step     <= '0;
      count         <= '0;
      grown         <= '0;
      k             <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      grown <= grown_next;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_addr))
          REG_INITIAL_SLOTS: initial_slots <= cfg_wdata;
          REG_GROW_STEP:     grow_step     <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (state == S_SCAN) begin
        k <= (k == LAST_K) ? '0 : k + IDX_W'(1);
      end else begin
        k <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op     <= op_t'(in_item.opcode);
      idx    <= in_item.slot_index;
      val    <= in_item.handle_value;
      size   <= CNT_W'(size_w);
      lim    <= CNT_W'(lim_w);
      base   <= CNT_W'(base_w);
      grow   <= dec_grow;
      status <= dec_status;
      slot   <= '0;
      rd     <= '0;
      done   <= 1'b0;
    end else begin
      status <= status_next;
      slot   <= slot_next;
      rd     <= rd_next;
      done   <= done_next;
    end
  end

endmodule

// ----- test/tb_slot_table_first_free_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_slot_table_first_free_allocator: self-checking bench for the slot table
// a shadow table predicts every reply beat; directed cases for each operation
// and growth rule, a back-pressure run, then random phases at several sizes
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_slot_table_first_free_allocator;
  import stf_pkg::*;

  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int SETTLE       = 4;
  localparam int PAD_S        = S_DATA_W - $bits(item_t);
  // highest opcode the field can carry; codes above OP_READ are undefined
  localparam logic [OPC_W-1:0] OPC_LAST = '1;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [REG_W-1:0]    cfg_addr = REG_INITIAL_SLOTS;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;  // opcode, slot_index, handle_value
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;       // status, slot_out, read_value, used_slots

  // shadow copy of the table and its registers
  logic [VAL_W-1:0] mdl_slot [CAPACITY];
  int               mdl_count;
  int               mdl_grown;
  int               mdl_initial;
  int               mdl_step;

  result_t predicted_q[$];  // replies still owed by the block, oldest first
  int      errors;
  int      cycles;
  bit      gaps_on;    // sender idles between beats
  bit      stalls_on;  // receiver drops tready in bursts
  int      hold_req;   // long receiver hold-off, picked up by the sink

  slot_table_first_free_allocator uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- shadow table

  function automatic int base_slots();
    return (mdl_initial > CAPACITY) ? CAPACITY : mdl_initial;
  endfunction

  function automatic int active_slots();
    int s;
    s = base_slots() + mdl_grown;
    return (s > CAPACITY) ? CAPACITY : s;
  endfunction

  // apply one operation to the shadow table and return the reply it owes
  function automatic result_t table_apply(input item_t it);
    result_t r;
    int size, lim, step, pos;
    logic [VAL_W-1:0] v;
    int idx;
    r = '0;
    r.status = STS_OK;
    size = active_slots();
    v = it.handle_value;
    idx = int'(it.slot_index);
    pos = -1;
    case (it.opcode)
      OP_ADD: begin
        if (v == '0) begin
          r.status = STS_ZERO;
        end else begin
          lim = size;
          step = (mdl_step != 0) ? mdl_step : DEFAULT_GROW;
          // full: grow first, unless that runs past capacity
          if (mdl_count >= size && size + step > CAPACITY) begin
            r.status = STS_NOMEM;
          end else begin
            if (mdl_count >= size) lim = size + step;
            for (int i = 0; i < lim; i++) begin
              if (pos < 0 && mdl_slot[i] == '0) pos = i;
            end
            // no hole even after growth: the growth is dropped
            if (pos < 0) begin
              r.status = STS_NOMEM;
            end else begin
              if (lim > size) mdl_grown = lim - base_slots();
              mdl_slot[pos] = v;
              mdl_count++;
              r.slot_out = SIDX_W'(pos);
            end
          end
        end
      end
      OP_WRITE: begin
        if (idx >= size) begin
          r.status = STS_BADIDX;
        end else begin
          if (mdl_slot[idx] == '0 && v != '0) mdl_count++;
          else if (mdl_slot[idx] != '0 && v == '0) mdl_count--;
          mdl_slot[idx] = v;
        end
      end
      OP_RMV_VAL: begin
        if (v == '0) begin
          r.status = STS_ZERO;
        end else if (mdl_count > size) begin
          r.status = STS_BADIDX;
        end else begin
          r.status = STS_NOTFOUND;
          for (int i = 0; i < size; i++) begin
            if (pos < 0 && mdl_slot[i] == v) pos = i;
          end
          if (pos >= 0) begin
            mdl_slot[pos] = '0;
            mdl_count--;
            r.status = STS_OK;
          end
        end
      end
      OP_RMV_IDX: begin
        if (v == '0 || idx >= size) begin
          r.status = STS_BADIDX;
        end else if (mdl_slot[idx] == v) begin
          mdl_slot[idx] = '0;
          mdl_count--;
        end else begin
          r.status = STS_NOMATCH;
        end
      end
      OP_READ: begin
        if (idx >= size) r.status = STS_BADIDX;
        else r.read_value = mdl_slot[idx];
      end
      default: r.status = STS_BADIDX;
    endcase
    r.used_slots = USED_W'(mdl_count);
    return r;
  endfunction

  // ---------------------------------------------------------------- reply checker

  task automatic check_reply(input result_t got);
    result_t want;
    if (predicted_q.size() == 0) begin
      $error("unexpected reply beat: status %0d, used_slots %0d", got.status, got.used_slots);
      errors++;
    end else begin
      want = predicted_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.slot_out !== want.slot_out) begin
        $error("slot_out: expected %0d, got %0d", want.slot_out, got.slot_out);
        errors++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %h, got %h", want.read_value, got.read_value);
        errors++;
      end
      if (got.used_slots !== want.used_slots) begin
        $error("used_slots: expected %0d, got %0d", want.used_slots, got.used_slots);
        errors++;
      end
    end
  endtask

  // outputs sampled on the rising edge, before the block updates them
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready)
      check_reply(result_t'(m_tdata[$bits(result_t)-1:0]));
  end

  // reply sink: random tready bursts, plus a long hold-off on request
  initial begin : reply_sink
    int n;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      n = 0;
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
      end else if (stalls_on && $urandom_range(0, 29) == 0) begin
        n = $urandom_range(1, 19);
      end
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- sender side

  // offer one beat, predict its reply once the block takes it
  task automatic send_item(input logic [OPC_W-1:0] opc, input logic [SIDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val);
    item_t it;
    int gap;
    it.opcode = opc;
    it.slot_index = idx;
    it.handle_value = val;
    gap = 0;
    if (gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 19);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      // half the gaps start only once the block has gone idle
      if ($urandom_range(0, 1) == 0)
        while (predicted_q.size() != 0) @(negedge clk);
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {{PAD_S{1'b0}}, it};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predicted_q.push_back(table_apply(it));
  endtask

  // stop offering and wait until every owed reply has arrived
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (predicted_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // register write, only with the block idle
  task automatic set_reg(input reg_idx_t a, input int v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= CFG_W'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (a == REG_INITIAL_SLOTS) mdl_initial = v & 'h1FF;
    else mdl_step = v & 'h1FF;
  endtask

  // empty every occupied active slot by writing zero
  task automatic clear_table();
    for (int i = 0; i < active_slots(); i++) begin
      if (mdl_slot[i] != '0) send_item(OP_WRITE, SIDX_W'(i), '0);
    end
  endtask

  // mostly values already in the table or from a small pool, so that
  // removes hit and duplicates appear
  function automatic logic [VAL_W-1:0] pick_value(input int size);
    int k;
    k = $urandom_range(0, 99);
    if (k < 30 && size > 0) return mdl_slot[$urandom_range(0, size - 1)];
    if (k < 55) return VAL_W'($urandom_range(1, 8));
    if (k < 63) return '0;
    if (k < 68) return '1;
    return VAL_W'($urandom);
  endfunction

  // ---------------------------------------------------------------- tests

  // every operation and its error cases at the reset settings
  task automatic test_basic_ops();
    send_item(OP_ADD, 8'd0, '0);                      // add of zero
    send_item(OP_ADD, 8'd0, 32'hFFFF_FFFF);           // lands in slot 0
    send_item(OP_ADD, 8'hFF, 32'd1);                  // slot 1
    send_item(OP_ADD, 8'd0, 32'h8000_0000);           // slot 2
    send_item(OP_READ, 8'd0, '0);
    send_item(OP_READ, 8'd15, 32'h1234_5678);         // last active slot, empty
    send_item(OP_READ, 8'd16, '0);                    // just past the active size
    send_item(OP_READ, 8'hFF, '0);
    send_item(OP_WRITE, 8'd5, 32'h5555_AAAA);
    send_item(OP_WRITE, 8'd1, '0);                    // write of zero empties slot 1
    send_item(OP_WRITE, 8'd1, '0);                    // already empty, count unchanged
    send_item(OP_ADD, 8'd0, 32'd7);                   // reuses the hole at slot 1
    send_item(OP_RMV_VAL, 8'd0, '0);                  // remove by value of zero
    send_item(OP_RMV_VAL, 8'd0, 32'h0000_1234);       // no match
    send_item(OP_RMV_VAL, 8'd9, 32'd7);
    send_item(OP_RMV_IDX, 8'd0, '0);                  // remove at index of zero
    send_item(OP_RMV_IDX, 8'd0, 32'd1);               // value differs
    send_item(OP_RMV_IDX, 8'd3, 32'd9);               // empty slot counts as mismatch
    send_item(OP_RMV_IDX, 8'd200, 32'd9);             // out of range
    send_item(OP_RMV_IDX, 8'd0, 32'hFFFF_FFFF);
    send_item(OP_WRITE, 8'hFF, 32'hDEAD_BEEF);        // out of range
    // undefined opcodes
    for (int c = int'(OP_READ) + 1; c <= int'(OPC_LAST); c++)
      send_item(OPC_W'(c), SIDX_W'($urandom), VAL_W'($urandom));
    clear_table();
  endtask

  // growth by the step, full after growth, growth past capacity, big sizes
  task automatic test_growth();
    set_reg(REG_INITIAL_SLOTS, 1);
    set_reg(REG_GROW_STEP, 1);
    send_item(OP_ADD, 8'd0, 32'h0000_00A1);
    send_item(OP_ADD, 8'd0, 32'h0000_00B2);           // table full: grows by one
    send_item(OP_ADD, 8'd0, 32'h0000_00C3);
    send_item(OP_READ, 8'd2, '0);
    send_item(OP_READ, 8'd3, '0);
    // shrink below the occupied count
    set_reg(REG_INITIAL_SLOTS, 0);
    send_item(OP_RMV_VAL, 8'd0, 32'h0000_00B2);       // count above active size
    send_item(OP_READ, 8'd2, '0);
    send_item(OP_ADD, 8'd0, 32'h0000_00D4);           // no hole even after growth
    set_reg(REG_GROW_STEP, 256);
    send_item(OP_ADD, 8'd0, 32'h0000_00D4);           // growth past capacity
    set_reg(REG_INITIAL_SLOTS, 1);
    set_reg(REG_GROW_STEP, 0);
    send_item(OP_ADD, 8'd0, 32'h0000_00D4);           // default step
    // initial size above capacity is clipped
    set_reg(REG_INITIAL_SLOTS, 511);
    send_item(OP_READ, 8'hFF, '0);
    send_item(OP_WRITE, 8'hFF, 32'h7FFF_FFFF);
    send_item(OP_RMV_IDX, 8'hFF, 32'h7FFF_FFFF);
    clear_table();
  endtask

  // receiver holds off long enough that the block stalls its input
  task automatic test_backpressure();
    gaps_on = 1'b0;
    wait_idle();
    hold_req = 1500;
    repeat (10) send_item(($urandom_range(0, 1) == 0) ? OP_READ : OP_ADD,
                          SIDX_W'($urandom_range(0, 20)), VAL_W'($urandom_range(1, 8)));
    wait_idle();
    clear_table();
    gaps_on = 1'b1;
  endtask

  task automatic run_random_phase(input int init_slots, input int step, input int n);
    logic [OPC_W-1:0]  opc;
    logic [SIDX_W-1:0] idx;
    logic [VAL_W-1:0]  val;
    int size, k;
    set_reg(REG_INITIAL_SLOTS, init_slots);
    set_reg(REG_GROW_STEP, step);
    repeat (n) begin
      size = active_slots();
      k = $urandom_range(0, 99);
      if (k < 45) opc = OP_ADD;
      else if (k < 58) opc = OP_WRITE;
      else if (k < 72) opc = OP_RMV_VAL;
      else if (k < 84) opc = OP_RMV_IDX;
      else if (k < 97) opc = OP_READ;
      else opc = OPC_W'($urandom_range(int'(OP_READ) + 1, int'(OPC_LAST)));
      if ($urandom_range(0, 4) != 0) idx = SIDX_W'($urandom_range(0, (size > 255) ? 255 : size));
      else idx = SIDX_W'($urandom);
      val = pick_value(size);
      // aim remove at index at the stored value most of the time
      if (opc == OP_RMV_IDX && int'(idx) < size && $urandom_range(0, 9) < 6)
        val = mdl_slot[idx];
      send_item(opc, idx, val);
    end
  endtask

  task automatic test_random();
    run_random_phase($urandom_range(1, 24), $urandom_range(1, 8), 100);
    run_random_phase(0, 2, 100);
    run_random_phase($urandom_range(1, 24), 256, 100);
    run_random_phase($urandom_range(1, 40), $urandom_range(0, 20), 100);
    run_random_phase(511, 511, 100);
    // closing phase runs without any idling
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    run_random_phase(256, 0, 100);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    for (int i = 0; i < CAPACITY; i++) mdl_slot[i] = '0;
    mdl_count   = 0;
    mdl_grown   = 0;
    mdl_initial = 16;
    mdl_step    = 0;
    errors      = 0;
    cycles      = 0;
    hold_req    = 0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_growth();
    test_backpressure();
    test_random();

    // let any stray beat show up before the verdict
    wait_idle();
    repeat (CAPACITY + 8) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- slot_table_first_free_allocator.f -----
hw/rtl/stf_pkg.sv
hw/rtl/stf_cell.sv
hw/rtl/stf_ctrl.sv
hw/rtl/slot_table_first_free_allocator.sv
test/tb_slot_table_first_free_allocator.sv
